[rtl/lcmc_pkg.sv]
// Shared types, constants and vector helpers of the lattice chain move classifier.
package lcmc_pkg;

  // Number of lattice components that take part; higher components read as zero.
  localparam int unsigned LCMC_DIMENSIONS = 3;

  // Default chain length; the link position counter saturates here.
  localparam int unsigned LCMC_CHAIN_LENGTH = 1024;

  // One link vector: three 2-bit two's complement components, x in the low bits.
  typedef logic [5:0] lvec_t;
  typedef logic signed [1:0] comp_t;

  // Move codes given at the end of each chain.
  typedef enum logic [2:0] {
    MOVE_FORBIDDEN        = 3'd0,
    MOVE_REPTATION        = 3'd1,
    MOVE_HERNIA           = 3'd2,
    MOVE_CROSSING         = 3'd3,
    MOVE_HERNIA_MIGRATION = 3'd4
  } move_kind_t;

  // Counts of changed links, saturating at three.
  typedef enum logic [1:0] {
    CHG_NONE  = 2'd0,
    CHG_ONE   = 2'd1,
    CHG_TWO   = 2'd2,
    CHG_MANY  = 2'd3
  } chg_count_t;

  // Chain summary handed from the tracker to the classifier.
  typedef struct packed {
    chg_count_t count;
    logic       adjacent;
    logic       single_at_end;
    lvec_t      s1;
    lvec_t      e1;
    lvec_t      s2;
    lvec_t      e2;
  } chain_t;

  // Packs three components, dropping the ones beyond the used dimensions.
  function automatic lvec_t pack_vec(comp_t cx, comp_t cy, comp_t cz);
    lvec_t v;
    v = {cz, cy, cx};
    for (int k = 0; k < 3; k++) begin
      if (k >= LCMC_DIMENSIONS) begin
        v[2*k +: 2] = 2'b00;
      end
    end
    return v;
  endfunction

  // Sign-extended component k of a packed vector.
  function automatic logic signed [2:0] comp_of(lvec_t v, int k);
    return {v[2*k+1], v[2*k +: 2]};
  endfunction

  // True when the dot product of two vectors is zero.
  function automatic logic dot_zero(lvec_t a, lvec_t b);
    logic signed [4:0] s;
    logic signed [5:0] p;
    s = '0;
    for (int k = 0; k < 3; k++) begin
      p = comp_of(a, k) * comp_of(b, k);
      s = s + p[4:0];
    end
    return (s == 5'sd0);
  endfunction

  // True when a is the component-wise negation of b.
  function automatic logic opposite(lvec_t a, lvec_t b);
    logic ok;
    logic signed [3:0] na;
    logic signed [3:0] nb;
    ok = 1'b1;
    for (int k = 0; k < 3; k++) begin
      na = 4'(comp_of(a, k));
      nb = -4'(comp_of(b, k));
      if (na != nb) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

[rtl/lcmc_ifs.sv]
// Handshake channels for link words and move code words.
interface lcmc_link_if;
  logic              valid;
  logic              ready;
  logic signed [1:0] start_x;
  logic signed [1:0] start_y;
  logic signed [1:0] start_z;
  logic signed [1:0] end_x;
  logic signed [1:0] end_y;
  logic signed [1:0] end_z;
  logic              last_link;

  modport source (
    output valid, start_x, start_y, start_z, end_x, end_y, end_z, last_link,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, start_z, end_x, end_y, end_z, last_link,
    output ready
  );
endinterface

interface lcmc_move_if;
  logic       valid;
  logic       ready;
  logic [2:0] move_kind;

  modport source (output valid, move_kind, input ready);
  modport sink (input valid, move_kind, output ready);
endinterface

[rtl/lcmc_tracker.sv]
// Per-chain state: link position, changed-link count and the first two changed links.
module lcmc_tracker #(
  parameter int unsigned CHAIN_LENGTH = lcmc_pkg::LCMC_CHAIN_LENGTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            link_go,
  input  lcmc_pkg::lvec_t link_before,
  input  lcmc_pkg::lvec_t link_after,
  input  logic            link_end,
  output lcmc_pkg::chain_t chain
);
  import lcmc_pkg::*;

  localparam int unsigned POS_W = $clog2(CHAIN_LENGTH + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(CHAIN_LENGTH);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] first_pos_r, first_pos_nxt;
  chg_count_t       cnt_r, cnt_upd;
  logic             adj_r, adj_upd;
  lvec_t            s1_r, e1_r, s2_r, e2_r;
  lvec_t            s1_upd, e1_upd, s2_upd, e2_upd;
  logic             changed;
  logic [POS_W:0]   first_plus_one;

  assign changed        = (link_before != link_after);
  assign first_plus_one = {1'b0, first_pos_r} + {{POS_W{1'b0}}, 1'b1};

  // Fold the current link into the chain summary.
  always_comb begin
    cnt_upd       = cnt_r;
    adj_upd       = adj_r;
    first_pos_nxt = first_pos_r;
    s1_upd        = s1_r;
    e1_upd        = e1_r;
    s2_upd        = s2_r;
    e2_upd        = e2_r;
    if (changed) begin
      case (cnt_r)
        CHG_NONE: begin
          first_pos_nxt = pos_r;
          s1_upd        = link_before;
          e1_upd        = link_after;
          cnt_upd       = CHG_ONE;
        end
        CHG_ONE: begin
          s2_upd  = link_before;
          e2_upd  = link_after;
          adj_upd = ({1'b0, pos_r} == first_plus_one);
          cnt_upd = CHG_TWO;
        end
        default: begin
          cnt_upd = CHG_MANY;
        end
      endcase
    end
  end

  // Summary including the current link, seen by the classifier.
  always_comb begin
    chain.count         = cnt_upd;
    chain.adjacent      = adj_upd;
    chain.single_at_end = (first_pos_nxt == '0) || (first_pos_nxt == pos_r);
    chain.s1            = s1_upd;
    chain.e1            = e1_upd;
    chain.s2            = s2_upd;
    chain.e2            = e2_upd;
  end

  // Position advances with saturation and restarts after the final link.
  always_comb begin
    if (link_end) begin
      pos_nxt = '0;
    end else if (pos_r < POS_MAX) begin
      pos_nxt = pos_r + 1'b1;
    end else begin
      pos_nxt = pos_r;
    end
  end

  // State registers; the final link clears everything for the next chain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      first_pos_r <= '0;
      cnt_r       <= CHG_NONE;
      adj_r       <= 1'b0;
      s1_r        <= '0;
      e1_r        <= '0;
      s2_r        <= '0;
      e2_r        <= '0;
    end else if (link_go) begin
      pos_r <= pos_nxt;
      if (link_end) begin
        first_pos_r <= '0;
        cnt_r       <= CHG_NONE;
        adj_r       <= 1'b0;
        s1_r        <= '0;
        e1_r        <= '0;
        s2_r        <= '0;
        e2_r        <= '0;
      end else begin
        first_pos_r <= first_pos_nxt;
        cnt_r       <= cnt_upd;
        adj_r       <= adj_upd;
        s1_r        <= s1_upd;
        e1_r        <= e1_upd;
        s2_r        <= s2_upd;
        e2_r        <= e2_upd;
      end
    end
  end

endmodule

[rtl/lcmc_classify.sv]
// Move code decision from the chain summary at the final link.
module lcmc_classify (
  input  lcmc_pkg::chain_t     chain,
  output lcmc_pkg::move_kind_t kind
);
  import lcmc_pkg::*;

  logic s1_z, s2_z, e1_z, e2_z;
  logic swap;
  logic single_kind_rep, single_kind_mig;

  assign s1_z = (chain.s1 == '0);
  assign s2_z = (chain.s2 == '0);
  assign e1_z = (chain.e1 == '0);
  assign e2_z = (chain.e2 == '0);
  assign swap = (chain.s1 == chain.e2) && (chain.s2 == chain.e1);

  assign single_kind_rep = s1_z || e1_z;
  assign single_kind_mig = dot_zero(chain.s1, chain.e1);

  // Rules are checked in priority order; the first match wins.
  always_comb begin
    kind = MOVE_FORBIDDEN;
    case (chain.count)
      CHG_ONE: begin
        if (chain.single_at_end) begin
          if (single_kind_rep) begin
            kind = MOVE_REPTATION;
          end else if (single_kind_mig) begin
            kind = MOVE_HERNIA_MIGRATION;
          end
        end
      end
      CHG_TWO: begin
        if (chain.adjacent) begin
          if ((s1_z != s2_z) && swap) begin
            kind = MOVE_REPTATION;
          end else if ((s1_z && s2_z && opposite(chain.e1, chain.e2)) ||
                       (e1_z && e2_z && opposite(chain.s1, chain.s2))) begin
            kind = MOVE_HERNIA;
          end else if (!s1_z && !s2_z && dot_zero(chain.s1, chain.s2) && swap) begin
            kind = MOVE_CROSSING;
          end else if (opposite(chain.s1, chain.s2) && opposite(chain.e1, chain.e2) &&
                       single_kind_mig) begin
            kind = MOVE_HERNIA_MIGRATION;
          end
        end
      end
      default: begin
        kind = MOVE_FORBIDDEN;
      end
    endcase
  end

endmodule

[rtl/lattice_chain_move_classifier.sv]
// Lattice chain move classifier: links of one chain in, one move code per chain out.
//
// Links enter one word per cycle, in chain order, unless a final link is
// stalled, and a word marked as the final link produces one move code word.
// A link waits in the input register while the state update and
// classification logic work on it; a final link's code goes from there to the
// result register when that link moves on. The result register parts the
// two sides: links keep flowing while a code waits, and only a final link
// stalls while the previous code has not been taken. Links at position
// CHAIN_LENGTH and beyond share one saturated position.
module lattice_chain_move_classifier #(
  parameter int unsigned CHAIN_LENGTH = lcmc_pkg::LCMC_CHAIN_LENGTH
) (
  input  logic          clk,
  input  logic          rst_n,
  lcmc_link_if.sink     in_ch,
  lcmc_move_if.source   out_ch
);
  import lcmc_pkg::*;

  logic       s1_v_r;
  lvec_t      s1_before_r, s1_after_r;
  logic       s1_end_r;
  logic       s1_go;
  logic       in_take;
  chain_t     chain;
  move_kind_t kind;
  logic       out_v_r, out_v_nxt;
  move_kind_t kind_r;

  // A held word moves on unless it is a final link and the code slot is full and not being taken.
  assign s1_go   = s1_v_r && (!s1_end_r || !out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || s1_go;
  assign in_take = in_ch.valid && in_ch.ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_before_r <= pack_vec(in_ch.start_x, in_ch.start_y, in_ch.start_z);
      s1_after_r  <= pack_vec(in_ch.end_x, in_ch.end_y, in_ch.end_z);
      s1_end_r    <= in_ch.last_link;
    end
  end

  lcmc_tracker #(
    .CHAIN_LENGTH(CHAIN_LENGTH)
  ) u_tracker (
    .clk        (clk),
    .rst_n      (rst_n),
    .link_go    (s1_go),
    .link_before(s1_before_r),
    .link_after (s1_after_r),
    .link_end   (s1_end_r),
    .chain      (chain)
  );

  lcmc_classify u_classify (
    .chain(chain),
    .kind (kind)
  );

  // Result register.
  always_comb begin
    if (s1_go && s1_end_r) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_end_r) begin
      kind_r <= kind;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.move_kind = kind_r;

endmodule
